[src/mm3_pkg.sv]
// Shared types, constants and helper functions for the MurmurHash3 x86_32 block.
// Used by mm3_ctrl, mm3_datapath and murmur3_x86_32_hash; depends on nothing else.
package mm3_pkg;

  localparam logic [31:0] MIX_C1     = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2     = 32'h1b873593;
  localparam logic [31:0] MIX_ADD    = 32'he6546b64;
  localparam logic [31:0] FIN_M1     = 32'h85ebca6b;
  localparam logic [31:0] FIN_M2     = 32'hc2b2ae35;
  localparam logic [31:0] SEED_RESET = 32'h9747b28c;

  localparam int OP_W = 4;

  localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
  localparam logic [OP_W-1:0] OP_K_C1   = 4'd1;
  localparam logic [OP_W-1:0] OP_K_C2   = 4'd2;
  localparam logic [OP_W-1:0] OP_BLK_H  = 4'd3;
  localparam logic [OP_W-1:0] OP_FIN_X  = 4'd4;
  localparam logic [OP_W-1:0] OP_FIN_XT = 4'd5;
  localparam logic [OP_W-1:0] OP_FIN_M1 = 4'd6;
  localparam logic [OP_W-1:0] OP_FIN_M2 = 4'd7;
  localparam logic [OP_W-1:0] OP_OUT    = 4'd8;

  typedef struct packed {
    logic            absorb;
    logic [OP_W-1:0] op;
  } mm3_cmd_t;

  typedef struct packed {
    logic pos_full;
    logic pos_nz;
    logic out_free;
  } mm3_stat_t;

  function automatic logic [31:0] rotl15(input logic [31:0] v);
    return {v[16:0], v[31:17]};
  endfunction

  function automatic logic [31:0] rotl13(input logic [31:0] v);
    return {v[18:0], v[31:19]};
  endfunction

endpackage

[src/murmur3_x86_32_hash.sv]
// Top level of the streaming MurmurHash3 x86_32 block.
// Depends on mm3_pkg, mm3_ctrl and mm3_datapath.
//
// Key bytes enter on the input channel (in_valid, in_stall), one item per
// transfer: key_byte with has_byte set adds a byte, last_byte ends the key.
// An item with has_byte clear and last_byte set finishes the key as it is,
// which hashes the empty key when no byte came before.
// The finished hash leaves on the output channel (out_valid, out_stall).
// Bytes are taken one per cycle while in_stall is low; after every fourth
// byte the block mixing step holds in_stall high while the single shared
// 32x32 multiplier scrambles the block and the running hash is updated.
// After the last item the block runs the tail scramble if a tail of one to
// three bytes remains, or the block mixing step if the last byte completes
// a block, then the avalanche and its multiplier passes (FIN_M1, FIN_M2).
// The output register lets the next key start while a hash waits; a stall
// on the output only holds the block once a second hash is finished.
// The seed register is written through cfg_write_en and cfg_write_data;
// the user must do so only while the block is idle; the block does not
// enforce it. A write reloads the running hash if the key has no byte yet.
// Synchronous reset sets the seed to its default and drops any partial key.
module murmur3_x86_32_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  key_byte,
  input  logic        has_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] hash_value,
  input  logic        cfg_write_en,
  input  logic [31:0] cfg_write_data
);
  import mm3_pkg::*;

  mm3_cmd_t  cmd;
  mm3_stat_t stat;
  logic      ready;

  assign in_stall = !ready;

  mm3_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .has_byte  (has_byte),
    .last_byte (last_byte),
    .stat      (stat),
    .ready     (ready),
    .cmd       (cmd)
  );

  mm3_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .key_byte       (key_byte),
    .has_byte       (has_byte),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .out_stall      (out_stall),
    .stat           (stat),
    .out_valid      (out_valid),
    .hash_value     (hash_value)
  );

endmodule

[src/mm3_ctrl.sv]
// Sequencing state machine for the MurmurHash3 x86_32 block.
// Depends on mm3_pkg; drives the command of mm3_datapath from its status.
module mm3_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              has_byte,
  input  logic              last_byte,
  input  mm3_pkg::mm3_stat_t stat,
  output logic              ready,
  output mm3_pkg::mm3_cmd_t  cmd
);
  import mm3_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_BLK_C1  = 4'd1;
  localparam logic [3:0] S_BLK_C2  = 4'd2;
  localparam logic [3:0] S_BLK_H   = 4'd3;
  localparam logic [3:0] S_TAIL_C1 = 4'd4;
  localparam logic [3:0] S_TAIL_C2 = 4'd5;
  localparam logic [3:0] S_FIN_X   = 4'd6;
  localparam logic [3:0] S_FIN_XT  = 4'd7;
  localparam logic [3:0] S_FIN_M1  = 4'd8;
  localparam logic [3:0] S_FIN_M2  = 4'd9;
  localparam logic [3:0] S_OUT     = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       pend_last;
  logic       pend_last_next;
  logic       accept;
  logic       blk_done;

  assign ready    = (state == S_IDLE);
  assign accept   = in_valid && ready;
  assign blk_done = has_byte && stat.pos_full;

  always_comb begin
    state_next     = state;
    pend_last_next = pend_last;
    cmd.absorb     = accept;
    cmd.op         = OP_NONE;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (blk_done) begin
            state_next     = S_BLK_C1;
            pend_last_next = last_byte;
          end else if (last_byte) begin
            state_next = (stat.pos_nz || has_byte) ? S_TAIL_C1 : S_FIN_X;
          end
        end
      end
      S_BLK_C1: begin
        cmd.op     = OP_K_C1;
        state_next = S_BLK_C2;
      end
      S_BLK_C2: begin
        cmd.op     = OP_K_C2;
        state_next = S_BLK_H;
      end
      S_BLK_H: begin
        cmd.op     = OP_BLK_H;
        state_next = pend_last ? S_FIN_X : S_IDLE;
      end
      S_TAIL_C1: begin
        cmd.op     = OP_K_C1;
        state_next = S_TAIL_C2;
      end
      S_TAIL_C2: begin
        cmd.op     = OP_K_C2;
        state_next = S_FIN_XT;
      end
      S_FIN_X: begin
        cmd.op     = OP_FIN_X;
        state_next = S_FIN_M1;
      end
      S_FIN_XT: begin
        cmd.op     = OP_FIN_XT;
        state_next = S_FIN_M1;
      end
      S_FIN_M1: begin
        cmd.op     = OP_FIN_M1;
        state_next = S_FIN_M2;
      end
      S_FIN_M2: begin
        cmd.op     = OP_FIN_M2;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend_last <= 1'b0;
    end else begin
      state     <= state_next;
      pend_last <= pend_last_next;
    end
  end

endmodule

[src/mm3_datapath.sv]
// Hash state, shared 32x32 multiplier and output register of the MurmurHash3 block.
// Depends on mm3_pkg; steered by the command from mm3_ctrl.
module mm3_datapath (
  input  logic               clk,
  input  logic               rst,
  input  mm3_pkg::mm3_cmd_t  cmd,
  input  logic [7:0]         key_byte,
  input  logic               has_byte,
  input  logic               cfg_write_en,
  input  logic [31:0]        cfg_write_data,
  input  logic               out_stall,
  output mm3_pkg::mm3_stat_t stat,
  output logic               out_valid,
  output logic [31:0]        hash_value
);
  import mm3_pkg::*;

  logic [31:0] seed;
  logic [31:0] running_hash;
  logic [31:0] block_acc;
  logic [1:0]  byte_pos;
  logic [31:0] key_length;
  logic [31:0] work;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] prod;
  logic [31:0] mix_x;
  logic [31:0] fin_x;
  logic [31:0] byte_shifted;

  assign stat.pos_full = (byte_pos == 2'd3);
  assign stat.pos_nz   = (byte_pos != 2'd0);
  assign stat.out_free = !out_valid || !out_stall;

  assign byte_shifted = {24'd0, key_byte} << {byte_pos, 3'd0};
  assign mix_x        = rotl13(running_hash ^ work);
  assign fin_x        = (cmd.op == OP_FIN_XT) ? (running_hash ^ work ^ key_length)
                                              : (running_hash ^ key_length);

  always_comb begin
    mul_a = work;
    mul_b = FIN_M1;
    case (cmd.op)
      OP_K_C1: begin
        mul_a = block_acc;
        mul_b = MIX_C1;
      end
      OP_K_C2: begin
        mul_a = rotl15(work);
        mul_b = MIX_C2;
      end
      OP_FIN_M2: begin
        mul_a = work ^ (work >> 13);
        mul_b = FIN_M2;
      end
      default: begin
        mul_a = work;
        mul_b = FIN_M1;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_K_C1, OP_K_C2, OP_FIN_M1, OP_FIN_M2: begin
        work <= prod;
      end
      OP_FIN_X, OP_FIN_XT: begin
        work <= fin_x ^ (fin_x >> 16);
      end
      default: begin
        work <= work;
      end
    endcase
    if (cmd.op == OP_OUT) begin
      hash_value <= work ^ (work >> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed         <= SEED_RESET;
      running_hash <= SEED_RESET;
      block_acc    <= 32'd0;
      byte_pos     <= 2'd0;
      key_length   <= 32'd0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.absorb && has_byte) begin
        block_acc  <= block_acc | byte_shifted;
        byte_pos   <= byte_pos + 2'd1;
        key_length <= key_length + 32'd1;
      end
      if (cmd.op == OP_BLK_H) begin
        running_hash <= mix_x + {mix_x[29:0], 2'b00} + MIX_ADD;
        block_acc    <= 32'd0;
      end
      if (cmd.op == OP_OUT) begin
        running_hash <= seed;
        block_acc    <= 32'd0;
        byte_pos     <= 2'd0;
        key_length   <= 32'd0;
        out_valid    <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_write_en) begin
        seed <= cfg_write_data;
        if (key_length == 32'd0) begin
          running_hash <= cfg_write_data;
        end
      end
    end
  end

endmodule
